// ===== rtl/core/ppps_pkg.sv =====
// shared types and constants for the ppm p6 stream parser
package ppps_pkg;

   typedef enum logic [2:0] {
      PH_MAGIC  = 3'd0,
      PH_ROWS   = 3'd1,
      PH_COLS   = 3'd2,
      PH_COLOUR = 3'd3,
      PH_PIXELS = 3'd4,
      PH_DONE   = 3'd5
   } phase_type;

   localparam logic [7:0] BYTE_NL    = 8'd10;
   localparam logic [7:0] BYTE_SP    = 8'd32;
   localparam logic [7:0] BYTE_ZERO  = 8'd48;
   localparam logic [7:0] BYTE_NINE  = 8'd57;
   localparam logic [1:0] CHANNEL_LAST = 2'd2;

   typedef struct packed {
      logic [7:0]  pixel_value;
      logic [15:0] row_index;
      logic [15:0] column_index;
      logic [1:0]  channel_index;
      logic        last_component;
      logic [15:0] image_rows;
      logic [15:0] image_columns;
      logic [15:0] max_colour;
   } pix_result_type;

endpackage

// ===== rtl/core/ppm_p6_stream_parser.sv =====
// top level of the ppm p6 stream parser
//
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    req_in_byte, req_new_image
//  rsp      out        rsp_valid/stall    pixel component, position, header numbers
//
// one request per cycle in steady state while rsp_stall is low: each byte goes
// through the input register, the combinational header/counter logic, and into
// the result register. a request gives at most one response, from the result register.
// reset is synchronous: phase goes to magic skip, header numbers and counters to zero.
// rsp_stall holds the result register; req_stall rises only when both stages are full.
module ppm_p6_stream_parser
   import ppps_pkg::*;
#(
   parameter int DIM_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_new_image,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_pixel_value,
   output logic [15:0] rsp_row_index,
   output logic [15:0] rsp_column_index,
   output logic [1:0]  rsp_channel_index,
   output logic        rsp_last_component,
   output logic [15:0] rsp_image_rows,
   output logic [15:0] rsp_image_columns,
   output logic [15:0] rsp_max_colour
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_new_ff;
   logic           advance;
   logic           step_fire;
   logic           req_fire;
   logic           res_valid;
   pix_result_type res_data;
   pix_result_type rsp_data;

   assign step_fire = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_fire  = req_valid && !req_stall;
   assign in_valid_in = req_fire ? 1'b1 : (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_in_byte;
         in_new_ff  <= req_new_image;
      end
   end

   ppps_parse #(
      .DIM_BITS (DIM_BITS)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .step_fire (step_fire),
      .in_byte   (in_byte_ff),
      .new_image (in_new_ff),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   ppps_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .step_fire (step_fire),
      .res_valid (res_valid),
      .res_data  (res_data),
      .advance   (advance),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_pixel_value    = rsp_data.pixel_value;
   assign rsp_row_index      = rsp_data.row_index;
   assign rsp_column_index   = rsp_data.column_index;
   assign rsp_channel_index  = rsp_data.channel_index;
   assign rsp_last_component = rsp_data.last_component;
   assign rsp_image_rows     = rsp_data.image_rows;
   assign rsp_image_columns  = rsp_data.image_columns;
   assign rsp_max_colour     = rsp_data.max_colour;

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_new_ff))
      else $error("held request lost or changed");

   a_in_load: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> in_valid_ff)
      else $error("accepted request not registered");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid)
      else $error("request stalled with free space");

endmodule

// ===== rtl/core/ppps_parse.sv =====
// header state machine, decimal accumulator and pixel position counters
module ppps_parse
   import ppps_pkg::*;
#(
   parameter int DIM_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           step_fire,
   input  logic [7:0]     in_byte,
   input  logic           new_image,
   output logic           res_valid,
   output pix_result_type res_data
);

   phase_type           phase_ff, phase_in, phase_eff, phase_nx;
   logic [DIM_BITS-1:0] rows_ff, rows_in, rows_eff, rows_nx;
   logic [DIM_BITS-1:0] cols_ff, cols_in, cols_eff, cols_nx;
   logic [DIM_BITS-1:0] colour_ff, colour_in, colour_eff, colour_nx;
   logic [DIM_BITS-1:0] row_ff, row_in, row_eff, row_nx;
   logic [DIM_BITS-1:0] col_ff, col_in, col_eff, col_nx;
   logic [1:0]          chan_ff, chan_in, chan_eff, chan_nx;

   logic [DIM_BITS-1:0] acc_sel, acc_next;
   logic [DIM_BITS+3:0] acc_wide;
   logic [7:0]          digit_diff;
   logic                is_digit;
   logic [DIM_BITS:0]   row_plus, col_plus;
   logic                last;

   function automatic logic [15:0] low16(input logic [DIM_BITS-1:0] v);
      logic [DIM_BITS+15:0] w;
      w = {16'b0, v};
      return w[15:0];
   endfunction

   // request with new_image set sees the reset state
   always_comb begin
      phase_eff  = new_image ? PH_MAGIC : phase_ff;
      rows_eff   = new_image ? '0 : rows_ff;
      cols_eff   = new_image ? '0 : cols_ff;
      colour_eff = new_image ? '0 : colour_ff;
      row_eff    = new_image ? '0 : row_ff;
      col_eff    = new_image ? '0 : col_ff;
      chan_eff   = new_image ? '0 : chan_ff;
   end

   // one shared decimal accumulator, only one number is open at a time
   always_comb begin
      case (phase_eff)
         PH_ROWS: begin
            acc_sel = rows_eff;
         end
         PH_COLS: begin
            acc_sel = cols_eff;
         end
         default: begin
            acc_sel = colour_eff;
         end
      endcase
      is_digit   = (in_byte >= BYTE_ZERO) && (in_byte <= BYTE_NINE);
      digit_diff = in_byte - BYTE_ZERO;
      acc_wide   = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0}
                 + {{DIM_BITS{1'b0}}, digit_diff[3:0]};
      if (!is_digit) begin
         acc_next = acc_sel;
      end else if (|acc_wide[DIM_BITS+3:DIM_BITS]) begin
         acc_next = '1;
      end else begin
         acc_next = acc_wide[DIM_BITS-1:0];
      end
   end

   always_comb begin
      row_plus = {1'b0, row_eff} + {{DIM_BITS{1'b0}}, 1'b1};
      col_plus = {1'b0, col_eff} + {{DIM_BITS{1'b0}}, 1'b1};
      last     = (row_plus == {1'b0, rows_eff}) && (col_plus == {1'b0, cols_eff})
               && (chan_eff == CHANNEL_LAST);

      phase_nx  = phase_eff;
      rows_nx   = rows_eff;
      cols_nx   = cols_eff;
      colour_nx = colour_eff;
      row_nx    = row_eff;
      col_nx    = col_eff;
      chan_nx   = chan_eff;
      res_valid = 1'b0;

      res_data.pixel_value    = in_byte;
      res_data.row_index      = low16(row_eff);
      res_data.column_index   = low16(col_eff);
      res_data.channel_index  = chan_eff;
      res_data.last_component = last;
      res_data.image_rows     = low16(rows_eff);
      res_data.image_columns  = low16(cols_eff);
      res_data.max_colour     = low16(colour_eff);

      case (phase_eff)
         PH_MAGIC: begin
            if (in_byte == BYTE_NL) phase_nx = PH_ROWS;
         end
         PH_ROWS: begin
            if (in_byte == BYTE_SP) phase_nx = PH_COLS;
            else rows_nx = acc_next;
         end
         PH_COLS: begin
            if (in_byte == BYTE_SP) phase_nx = PH_COLOUR;
            else cols_nx = acc_next;
         end
         PH_COLOUR: begin
            if (in_byte == BYTE_NL) begin
               phase_nx = ((rows_eff == '0) || (cols_eff == '0)) ? PH_DONE : PH_PIXELS;
               row_nx   = '0;
               col_nx   = '0;
               chan_nx  = '0;
            end else begin
               colour_nx = acc_next;
            end
         end
         PH_PIXELS: begin
            res_valid = 1'b1;
            if (last) begin
               phase_nx = PH_DONE;
            end else if (chan_eff != CHANNEL_LAST) begin
               chan_nx = chan_eff + 2'd1;
            end else begin
               chan_nx = '0;
               if (col_plus < {1'b0, cols_eff}) begin
                  col_nx = col_plus[DIM_BITS-1:0];
               end else begin
                  col_nx = '0;
                  row_nx = row_plus[DIM_BITS-1:0];
               end
            end
         end
         default: begin
            phase_nx = phase_eff;
         end
      endcase

      phase_in  = step_fire ? phase_nx  : phase_ff;
      rows_in   = step_fire ? rows_nx   : rows_ff;
      cols_in   = step_fire ? cols_nx   : cols_ff;
      colour_in = step_fire ? colour_nx : colour_ff;
      row_in    = step_fire ? row_nx    : row_ff;
      col_in    = step_fire ? col_nx    : col_ff;
      chan_in   = step_fire ? chan_nx   : chan_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_MAGIC;
         rows_ff   <= '0;
         cols_ff   <= '0;
         colour_ff <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
         chan_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         rows_ff   <= rows_in;
         cols_ff   <= cols_in;
         colour_ff <= colour_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         chan_ff   <= chan_in;
      end
   end

   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      chan_ff <= CHANNEL_LAST)
      else $error("channel counter out of range");

   a_pixels_nonempty: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PIXELS |-> (rows_ff != '0) && (cols_ff != '0))
      else $error("pixel phase with empty image");

   a_pos_in_image: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PIXELS |-> (row_ff < rows_ff) && (col_ff < cols_ff))
      else $error("pixel position outside image");

   a_last_done: assert property (@(posedge clock) disable iff (reset)
      step_fire && res_valid && res_data.last_component |=> phase_ff == PH_DONE)
      else $error("parser not done after last component");

endmodule

// ===== rtl/core/ppps_out_reg.sv =====
// result register between the parser and the response channel
module ppps_out_reg
   import ppps_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step_fire,
   input  logic           res_valid,
   input  pix_result_type res_data,
   output logic           advance,
   input  logic           rsp_stall,
   output logic           rsp_valid,
   output pix_result_type rsp_data
);

   logic           valid_ff, valid_in;
   pix_result_type data_ff;

   // the slot frees when empty or when its request leaves this cycle
   assign advance  = !valid_ff || !rsp_stall;
   assign valid_in = advance ? (step_fire && res_valid) : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= res_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   a_hold_no_loss: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_stall |=> valid_ff && $stable(data_ff))
      else $error("stalled result lost or changed");

   a_no_step_when_full: assert property (@(posedge clock) disable iff (reset)
      step_fire |-> advance)
      else $error("parser stepped while result slot busy");

   a_load_on_result: assert property (@(posedge clock) disable iff (reset)
      step_fire && res_valid |=> valid_ff)
      else $error("result not captured");

endmodule
